// File: rtl/control_sequence_text_display_top_assert.svh
// Assertion macros for the text display block.
// Used by control_sequence_text_display_top; no other dependencies.
`ifndef CONTROL_SEQUENCE_TEXT_DISPLAY_TOP_ASSERT_SVH
`define CONTROL_SEQUENCE_TEXT_DISPLAY_TOP_ASSERT_SVH
`ifndef SYNTH
`define CSD_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define CSD_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define CSD_ASSERT_IMP(label, clk, rst, ante, cons)
`define CSD_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/csd_pkg.sv
// Shared types and constants for the text display block.
// No dependencies; imported by csd_cell and the top level.
package csd_pkg;

   localparam int COORD_W = 4;

   localparam logic [1:0] REQ_FEED  = 2'd0;
   localparam logic [1:0] REQ_READ  = 2'd1;
   localparam logic [1:0] REQ_RESET = 2'd2;

   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_CARET   = 8'h5E;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_B       = 8'h62;
   localparam logic [7:0] CH_C       = 8'h63;
   localparam logic [7:0] CH_D       = 8'h64;
   localparam logic [7:0] CH_E       = 8'h65;
   localparam logic [7:0] CH_H       = 8'h68;
   localparam logic [7:0] CH_I       = 8'h69;
   localparam logic [7:0] CH_L       = 8'h6C;
   localparam logic [7:0] CH_O       = 8'h6F;
   localparam logic [7:0] CH_R       = 8'h72;
   localparam logic [7:0] CH_U       = 8'h75;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [7:0]         data_byte;
      logic [COORD_W-1:0] read_row;
      logic [COORD_W-1:0] read_col;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]         cell_char;
      logic [COORD_W-1:0] cursor_row;
      logic [COORD_W-1:0] cursor_col;
      logic               insert_on;
   } rsp_payload_type;

   // per-cell update select for one row edit
   typedef struct packed {
      logic take_new;
      logic take_left;
      logic blank;
   } cell_ctrl_type;

endpackage

// File: rtl/csd_cell.sv
// One character cell of the row edit chain.
// Depends on csd_pkg (cell_ctrl_type, CH_SPACE).
module csd_cell (
   input  logic                  clock,
   input  logic                  en,
   input  csd_pkg::cell_ctrl_type ctrl,
   input  logic [7:0]            own_char,
   input  logic [7:0]            left_char,
   input  logic [7:0]            new_char,
   output logic [7:0]            char_ff
);
   import csd_pkg::*;

   logic [7:0] char_in;

   always_comb begin
      if (ctrl.blank) begin
         char_in = CH_SPACE;
      end else if (ctrl.take_new) begin
         char_in = new_char;
      end else if (ctrl.take_left) begin
         char_in = left_char;
      end else begin
         char_in = own_char;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         char_ff <= char_in;
      end
   end

endmodule

// File: rtl/control_sequence_text_display_top.sv
// Text display controller: escape decoder, row memory and a chain of cells.
// Depends on csd_pkg, csd_cell and control_sequence_text_display_top_assert.svh.
// The response follows the row read at the transfer, the cell update and the
// write-back with response; req_ready returns only after write-back, which a held
// response stalls, so a new request is taken only once the last is through. Sync reset
// clears cursor, mode, escape state and row valid bits; unwritten rows read as spaces.
module control_sequence_text_display_top #(
   parameter int ROWS = 10,
   parameter int COLS = 10
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  csd_pkg::req_payload_type  req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output csd_pkg::rsp_payload_type  rsp_payload
);
   import csd_pkg::*;

`include "control_sequence_text_display_top_assert.svh"

   localparam int RA_W  = $clog2(ROWS);
   localparam int CA_W  = $clog2(COLS);
   localparam int ROW_W = COLS * 8;

   // sequencer states
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_LOAD = 2'd1;
   localparam logic [1:0] ST_WB   = 2'd2;

   // escape phases
   localparam logic [1:0] ESC_IDLE  = 2'd0;
   localparam logic [1:0] ESC_CARET = 2'd1;
   localparam logic [1:0] ESC_ROW   = 2'd2;

   // row edit kinds
   localparam logic [1:0] OP_NONE  = 2'd0;
   localparam logic [1:0] OP_PUT   = 2'd1;
   localparam logic [1:0] OP_INS   = 2'd2;
   localparam logic [1:0] OP_ERASE = 2'd3;

   // ---------------- control state ----------------
   logic [1:0]         state_ff, state_in;
   logic [COORD_W-1:0] row_ff, row_in;
   logic [COORD_W-1:0] col_ff, col_in;
   logic               ins_ff, ins_in;
   logic [1:0]         esc_ff, esc_in;
   logic [COORD_W-1:0] pend_ff, pend_in;
   logic [ROWS-1:0]    vld_ff;
   logic               clr_all;

   // ---------------- per-item latched request ----------------
   logic [1:0]      op_kind_ff, op_kind_in;
   logic [CA_W-1:0] op_col_ff;
   logic [7:0]      op_char_ff, op_char_in;
   logic [RA_W-1:0] op_row_ff;
   logic            rd_ok_ff, rd_ok;
   logic [CA_W-1:0] rcol_ff;
   logic            row_vld_rd_ff;

   // ---------------- row memory ----------------
   logic [ROW_W-1:0] mem_ff [ROWS];
   logic [ROW_W-1:0] row_rd_ff;
   logic [ROW_W-1:0] row_wr;
   logic [RA_W-1:0]  rd_addr;
   logic             mem_we;

   // ---------------- response ----------------
   rsp_payload_type rsp_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            wb_go;
   logic            req_fire;

   logic [7:0] ch;
   logic [7:0] dig;
   logic       is_digit;
   logic       put_req;

   logic [7:0] row_src [COLS];
   logic [7:0] cell_q  [COLS];

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign ch        = req_payload.data_byte;
   assign dig       = ch - CH_ZERO;
   assign is_digit  = (ch >= CH_ZERO);

   // Read request only hits the row when in range; result is zero otherwise.
   assign rd_ok = (req_payload.req_type == REQ_READ) &&
                  (req_payload.read_row < COORD_W'(ROWS)) &&
                  (req_payload.read_col < COORD_W'(COLS));
   assign rd_addr = rd_ok ? req_payload.read_row[RA_W-1:0] : row_ff[RA_W-1:0];

   // Escape decoder and cursor update, resolved at the request transfer.
   always_comb begin
      row_in     = row_ff;
      col_in     = col_ff;
      ins_in     = ins_ff;
      esc_in     = esc_ff;
      pend_in    = pend_ff;
      clr_all    = 1'b0;
      put_req    = 1'b0;
      op_kind_in = OP_NONE;
      op_char_in = ch;
      unique case (req_payload.req_type)
         REQ_FEED: begin
            if (ch != CH_NEWLINE) begin
               case (esc_ff)
                  ESC_CARET: begin
                     esc_in = ESC_IDLE;
                     case (ch)
                        CH_B: col_in = '0;
                        CH_C: clr_all = 1'b1;
                        CH_D: if (row_ff < COORD_W'(ROWS - 1)) row_in = row_ff + COORD_W'(1);
                        CH_E: op_kind_in = OP_ERASE;
                        CH_H: begin
                           row_in = '0;
                           col_in = '0;
                        end
                        CH_I: ins_in = 1'b1;
                        CH_L: if (col_ff != '0) col_in = col_ff - COORD_W'(1);
                        CH_O: ins_in = 1'b0;
                        CH_R: if (col_ff < COORD_W'(COLS - 1)) col_in = col_ff + COORD_W'(1);
                        CH_U: if (row_ff != '0) row_in = row_ff - COORD_W'(1);
                        CH_CARET: put_req = 1'b1;
                        default: begin
                           if (is_digit && (dig < 8'(ROWS))) begin
                              pend_in = dig[COORD_W-1:0];
                              esc_in  = ESC_ROW;
                           end
                        end
                     endcase
                  end
                  ESC_ROW: begin
                     esc_in = ESC_IDLE;
                     if (is_digit && (dig < 8'(COLS))) begin
                        row_in = pend_ff;
                        col_in = dig[COORD_W-1:0];
                     end
                  end
                  default: begin
                     if (ch == CH_CARET) begin
                        esc_in = ESC_CARET;
                     end else begin
                        esc_in  = ESC_IDLE;
                        put_req = 1'b1;
                     end
                  end
               endcase
            end
            if (put_req) begin
               op_kind_in = ins_ff ? OP_INS : OP_PUT;
               if (col_ff < COORD_W'(COLS - 1)) col_in = col_ff + COORD_W'(1);
            end
         end
         REQ_RESET: begin
            row_in  = '0;
            col_in  = '0;
            ins_in  = 1'b0;
            esc_in  = ESC_IDLE;
            pend_in = '0;
            clr_all = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Sequencer: transfer -> load cells -> write back and respond.
   assign wb_go  = (state_ff == ST_WB) && (!rsp_valid_ff || rsp_ready);
   assign mem_we = wb_go && (op_kind_ff != OP_NONE);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_fire) state_in = ST_LOAD;
         ST_LOAD: state_in = ST_WB;
         ST_WB:   if (wb_go) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (wb_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_ff       <= '0;
         col_ff       <= '0;
         ins_ff       <= 1'b0;
         esc_ff       <= ESC_IDLE;
         pend_ff      <= '0;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            row_ff  <= row_in;
            col_ff  <= col_in;
            ins_ff  <= ins_in;
            esc_ff  <= esc_in;
            pend_ff <= pend_in;
            if (clr_all) vld_ff <= '0;
         end
         if (mem_we) vld_ff[op_row_ff] <= 1'b1;
      end
   end

   // Per-item latches; edit position is the cursor before this item.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_kind_ff    <= op_kind_in;
         op_char_ff    <= op_char_in;
         op_col_ff     <= col_ff[CA_W-1:0];
         op_row_ff     <= row_ff[RA_W-1:0];
         rd_ok_ff      <= rd_ok;
         rcol_ff       <= req_payload.read_col[CA_W-1:0];
         row_vld_rd_ff <= vld_ff[rd_addr];
      end
   end

   // Row memory: one read at transfer, one write at write-back when the item edits the row.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         row_rd_ff <= mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[op_row_ff] <= row_wr;
      end
   end

   // Cell chain: each cell sees its own old char and its left neighbor's.
   for (genvar k = 0; k < COLS; k++) begin : g_cell
      cell_ctrl_type ctrl;

      assign row_src[k] = row_vld_rd_ff ? row_rd_ff[k*8 +: 8] : CH_SPACE;
      assign ctrl.take_new  = ((op_kind_ff == OP_PUT) || (op_kind_ff == OP_INS)) &&
                              (op_col_ff == CA_W'(k));
      assign ctrl.take_left = (op_kind_ff == OP_INS) && (CA_W'(k) > op_col_ff);
      assign ctrl.blank     = (op_kind_ff == OP_ERASE) && (CA_W'(k) >= op_col_ff);

      csd_cell u_cell (
         .clock     (clock),
         .en        (state_ff == ST_LOAD),
         .ctrl      (ctrl),
         .own_char  (row_src[k]),
         .left_char ((k == 0) ? CH_SPACE : row_src[(k == 0) ? 0 : k - 1]),
         .new_char  (op_char_ff),
         .char_ff   (cell_q[k])
      );

      assign row_wr[k*8 +: 8] = cell_q[k];
   end

   // Response register, loaded at write-back.
   always_ff @(posedge clock) begin
      if (wb_go) begin
         rsp_ff.cell_char  <= rd_ok_ff ? cell_q[rcol_ff] : 8'h00;
         rsp_ff.cursor_row <= row_ff;
         rsp_ff.cursor_col <= col_ff;
         rsp_ff.insert_on  <= ins_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // ---------------- checks ----------------
   `CSD_ASSERT_IMP(a_row_range, clock, reset, 1'b1, row_ff < COORD_W'(ROWS))
   `CSD_ASSERT_IMP(a_col_range, clock, reset, 1'b1, col_ff < COORD_W'(COLS))
   `CSD_ASSERT_IMP(a_pend_range, clock, reset, esc_ff == ESC_ROW, pend_ff < COORD_W'(ROWS))
   `CSD_ASSERT_IMP(a_rsp_from_wb, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_WB)
   `CSD_ASSERT_NXT(a_clear_rows, clock, reset, req_fire && clr_all, vld_ff == '0)

endmodule

// File: tb/control_sequence_text_display_top_tb.sv
// Self-checking testbench for the control-sequence text display block.
// Depends on csd_pkg and control_sequence_text_display_top. A screen/cursor
// tracker predicts every response; directed and random tests share one driver.
module control_sequence_text_display_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import csd_pkg::*;

   localparam int ROWS = 10;
   localparam int COLS = 10;
   localparam int MAX_CYCLES = 200000;
   localparam int DRAIN_CYCLES = 12;
   localparam int RANDOM_ITEMS = 1100;

   // Request type 3 has no name in the package; the block treats it as a no-op.
   localparam logic [1:0] REQ_NOP = 2'd3;

   // Escape decoder phase of the tracker.
   typedef enum logic [1:0] {
      ESC_IDLE = 2'd0,
      ESC_CODE = 2'd1,
      ESC_COL  = 2'd2
   } esc_phase_type;

   logic            clock;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;

   // Tracker copy of the display.
   logic [7:0]      screen_shadow [ROWS][COLS];
   logic [3:0]      cursor_row_q;
   logic [3:0]      cursor_col_q;
   logic            insert_q;
   esc_phase_type   esc_phase;
   logic [3:0]      pending_row_q;

   rsp_payload_type expected_status [$];
   int              item_count = 0;
   int              error_count = 0;
   int              cycle_count = 0;
   bit              idle_on = 1'b1;

   // Single-character escape codes used by the random traffic (clear is drawn
   // separately so the screen keeps content most of the time).
   logic [7:0] cursor_codes [10] = '{CH_B, CH_D, CH_E, CH_H, CH_I,
                                     CH_L, CH_O, CH_R, CH_U, CH_CARET};

   control_sequence_text_display_top #(
      .ROWS(ROWS),
      .COLS(COLS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // ---------------------------------------------------------------------
   // Tracker
   // ---------------------------------------------------------------------
   function automatic void blank_screen();
      for (int r = 0; r < ROWS; r++)
         for (int c = 0; c < COLS; c++)
            screen_shadow[r][c] = CH_SPACE;
   endfunction

   function automatic void reset_display();
      blank_screen();
      cursor_row_q  = '0;
      cursor_col_q  = '0;
      insert_q      = 1'b0;
      esc_phase     = ESC_IDLE;
      pending_row_q = '0;
   endfunction

   // Write at the cursor; insert mode pushes the row tail right, last column
   // falls off. Cursor then steps right but sticks at the last column.
   function automatic void put_glyph(logic [7:0] ch);
      if (insert_q) begin
         for (int k = COLS - 1; k > cursor_col_q; k--)
            screen_shadow[cursor_row_q][k] = screen_shadow[cursor_row_q][k-1];
      end
      screen_shadow[cursor_row_q][cursor_col_q] = ch;
      if (cursor_col_q < COLS - 1)
         cursor_col_q = cursor_col_q + 1'b1;
   endfunction

   function automatic rsp_payload_type track_display(req_payload_type item);
      rsp_payload_type status;
      int              digit;
      status = '0;
      digit  = int'(item.data_byte) - int'(CH_ZERO);
      case (item.req_type)
         REQ_FEED: begin
            // newline is swallowed in every phase, phase kept
            if (item.data_byte != CH_NEWLINE) begin
               case (esc_phase)
                  ESC_CODE: begin
                     esc_phase = ESC_IDLE;
                     case (item.data_byte)
                        CH_B: cursor_col_q = '0;
                        CH_C: blank_screen();
                        CH_D: if (cursor_row_q < ROWS - 1) cursor_row_q = cursor_row_q + 1'b1;
                        CH_E: begin
                           for (int k = cursor_col_q; k < COLS; k++)
                              screen_shadow[cursor_row_q][k] = CH_SPACE;
                        end
                        CH_H: begin
                           cursor_row_q = '0;
                           cursor_col_q = '0;
                        end
                        CH_I: insert_q = 1'b1;
                        CH_L: if (cursor_col_q > 0) cursor_col_q = cursor_col_q - 1'b1;
                        CH_O: insert_q = 1'b0;
                        CH_R: if (cursor_col_q < COLS - 1) cursor_col_q = cursor_col_q + 1'b1;
                        CH_U: if (cursor_row_q > 0) cursor_row_q = cursor_row_q - 1'b1;
                        CH_CARET: put_glyph(CH_CARET);
                        default: begin
                           // row digit opens the placement, anything else drops
                           if (digit >= 0 && digit < ROWS) begin
                              pending_row_q = digit[3:0];
                              esc_phase     = ESC_COL;
                           end
                        end
                     endcase
                  end
                  ESC_COL: begin
                     esc_phase = ESC_IDLE;
                     if (digit >= 0 && digit < COLS) begin
                        cursor_row_q = pending_row_q;
                        cursor_col_q = digit[3:0];
                     end
                  end
                  default: begin
                     if (item.data_byte == CH_CARET)
                        esc_phase = ESC_CODE;
                     else
                        put_glyph(item.data_byte);
                  end
               endcase
            end
         end
         REQ_READ: begin
            if (item.read_row < ROWS && item.read_col < COLS)
               status.cell_char = screen_shadow[item.read_row][item.read_col];
         end
         REQ_RESET: reset_display();
         default: ;
      endcase
      status.cursor_row = cursor_row_q;
      status.cursor_col = cursor_col_q;
      status.insert_on  = insert_q;
      return status;
   endfunction

   // ---------------------------------------------------------------------
   // Request driver: random gap, then hold valid until the transfer.
   // Called at a rising edge; returns at the edge of the transfer.
   // ---------------------------------------------------------------------
   task automatic send_item(logic [1:0] kind, logic [7:0] data,
                            logic [3:0] row, logic [3:0] col);
      req_payload_type item;
      int              gap;
      item.req_type  = kind;
      item.data_byte = data;
      item.read_row  = row;
      item.read_col  = col;
      gap = idle_on ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      expected_status.push_back(track_display(item));
      item_count++;
   endtask

   // Feed a byte; the unused read coordinates carry random noise.
   task automatic feed_byte(logic [7:0] data);
      send_item(REQ_FEED, data, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
   endtask

   task automatic read_cell(logic [3:0] row, logic [3:0] col);
      send_item(REQ_READ, 8'($urandom_range(0, 255)), row, col);
   endtask

   task automatic escape(logic [7:0] code);
      feed_byte(CH_CARET);
      feed_byte(code);
   endtask

   // ---------------------------------------------------------------------
   // Response side: random stall per transfer, idle stretches follow idle_on.
   // ---------------------------------------------------------------------
   initial begin : rsp_sink
      int stall;
      forever begin
         stall = idle_on ? $urandom_range(0, 5) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && !reset));
      end
   end

   // Compare each response transfer with the oldest prediction.
   always @(posedge clock) begin : rsp_check
      rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_status.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("unexpected response: char %h row %0d col %0d ins %0d",
                        rsp_payload.cell_char, rsp_payload.cursor_row,
                        rsp_payload.cursor_col, rsp_payload.insert_on);
         end else begin
            want = expected_status.pop_front();
            if (rsp_payload.cell_char  !== want.cell_char  ||
                rsp_payload.cursor_row !== want.cursor_row ||
                rsp_payload.cursor_col !== want.cursor_col ||
                rsp_payload.insert_on  !== want.insert_on) begin
               error_count++;
               if (error_count <= 10)
                  $display({"mismatch: got char %h row %0d col %0d ins %0d,",
                            " expected char %h row %0d col %0d ins %0d"},
                           rsp_payload.cell_char, rsp_payload.cursor_row,
                           rsp_payload.cursor_col, rsp_payload.insert_on,
                           want.cell_char, want.cursor_row,
                           want.cursor_col, want.insert_on);
            end
         end
      end
   end

   // Watchdog: a hung handshake ends the run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > MAX_CYCLES) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Field extremes, edge reads and cursor saturation at the far corner.
   task automatic test_edges();
      read_cell(4'd0, 4'd0);
      read_cell(4'd15, 4'd15);
      read_cell(4'd10, 4'd3);
      read_cell(4'd2, 4'd10);
      feed_byte(8'h00);
      feed_byte(8'hFF);
      feed_byte(CH_CARET);
      feed_byte(CH_ZERO + 8'd9);
      feed_byte(CH_ZERO + 8'd9);
      feed_byte(8'h5A);             // last column, cursor stays put
      read_cell(4'd9, 4'd9);
      escape(CH_R);                 // right at last column
      escape(CH_D);                 // down at last row
   endtask

   // Every escape code once, with insert mode shifting a partly filled row.
   task automatic test_escape_codes();
      escape(CH_H);
      escape(CH_U);                 // up at row 0
      escape(CH_L);                 // left at column 0
      feed_byte(8'h41);
      escape(CH_I);
      escape(CH_B);
      feed_byte(8'h42);             // shifts 'A' right
      read_cell(4'd0, 4'd1);
      escape(CH_CARET);             // literal caret, inserted
      escape(CH_E);
      escape(CH_O);
      escape(CH_R);
      escape(CH_D);
      escape(CH_C);
      read_cell(4'd0, 4'd0);
   endtask

   // Newline in each phase, dropped escapes, no-op and reset mid-escape.
   task automatic test_special_cases();
      feed_byte(CH_NEWLINE);
      feed_byte(CH_CARET);
      feed_byte(CH_NEWLINE);        // still waiting for the code
      feed_byte(CH_ZERO + 8'd5);
      feed_byte(CH_NEWLINE);        // still waiting for the column
      feed_byte(CH_ZERO + 8'd7);
      escape(8'h7A);                // unknown code
      escape(8'h3A);                // colon is not a row digit
      feed_byte(CH_CARET);
      feed_byte(CH_ZERO + 8'd3);
      feed_byte(8'h3A);             // bad column digit, cursor stays
      send_item(REQ_NOP, 8'hA5, 4'hF, 4'h0);
      feed_byte(CH_CARET);
      send_item(REQ_RESET, 8'h5A, 4'h0, 4'hF);
      feed_byte(8'h51);             // plain again after reset
      read_cell(4'd0, 4'd0);
   endtask

   // Mostly well-formed escapes and text, some noise, broken escapes and reads.
   task automatic test_random_traffic(int count);
      int         target;
      int         pick;
      logic [7:0] code;
      target = item_count + count;
      while (item_count < target) begin
         // one quiet stretch with no idling every few hundred transfers
         idle_on = ((item_count / 60) % 5) != 4;
         pick = $urandom_range(0, 99);
         if (pick < 32) begin
            feed_byte(8'($urandom_range(8'h21, 8'h7E)));
         end else if (pick < 50) begin
            code = cursor_codes[$urandom_range(0, 9)];
            escape(code);
         end else if (pick < 60) begin
            feed_byte(CH_CARET);
            feed_byte(CH_ZERO + 8'($urandom_range(0, ROWS - 1)));
            feed_byte(CH_ZERO + 8'($urandom_range(0, COLS - 1)));
         end else if (pick < 76) begin
            if ($urandom_range(0, 9) == 0)
               read_cell(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
            else
               read_cell(4'($urandom_range(0, ROWS - 1)), 4'($urandom_range(0, COLS - 1)));
         end else if (pick < 81) begin
            feed_byte(8'($urandom_range(0, 255)));
         end else if (pick < 84) begin
            escape(8'($urandom_range(0, 255)));
         end else if (pick < 87) begin
            feed_byte(CH_CARET);
            feed_byte(CH_ZERO + 8'($urandom_range(0, ROWS - 1)));
            feed_byte(8'($urandom_range(0, 255)));
         end else if (pick < 90) begin
            feed_byte(CH_NEWLINE);
         end else if (pick < 93) begin
            send_item(REQ_NOP, 8'($urandom_range(0, 255)),
                      4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
         end else if (pick < 94) begin
            send_item(REQ_RESET, 8'($urandom_range(0, 255)),
                      4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
         end else if (pick < 95) begin
            escape(CH_C);
         end else begin
            // lower-case text at the current cursor
            feed_byte(8'($urandom_range(8'h61, 8'h7A)));
         end
      end
      idle_on = 1'b1;
   endtask

   initial begin
      reset_display();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_edges();
      test_escape_codes();
      test_special_cases();
      test_random_traffic(RANDOM_ITEMS);

      req_valid <= 1'b0;
      while (expected_status.size() != 0) @(posedge clock);
      // drain to catch any stray response
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && expected_status.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
